>>> src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape and UTF-8 block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	// Result kinds carried in tuser.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Default cap on the reported decoded length.
	localparam int unsigned MAX_STRING_LEN_DEF = 32'd65535;

	// Largest number of results one input byte can cause.
	localparam int unsigned BURST_MAX = 4;

	// All results caused by one accepted input byte.
	typedef struct packed {
		logic [2:0]      count;
		logic [1:0]      kind;
		logic            esc;
		logic [15:0]     len;
		logic [3:0][7:0] bytes;
	} jsu_burst_t;

endpackage

`default_nettype wire

>>> src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Per-string decode state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode #(
	parameter int unsigned MAX_STRING_LEN = jsu_pkg::MAX_STRING_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              raw_mode,
	input  wire logic              clear,
	output jsu_pkg::jsu_burst_t    burst
);

	localparam logic [15:0] LEN_CAP =
		(MAX_STRING_LEN < 32'd65535) ? 16'(MAX_STRING_LEN) : 16'hFFFF;

	localparam logic [3:0] PH_PLAIN  = 4'd0;
	localparam logic [3:0] PH_ESC    = 4'd1;
	localparam logic [3:0] PH_HEX1   = 4'd2;
	localparam logic [3:0] PH_HEX4   = 4'd5;
	localparam logic [3:0] PH_SBS    = 4'd6;
	localparam logic [3:0] PH_SU     = 4'd7;
	localparam logic [3:0] PH_SHEX1  = 4'd8;
	localparam logic [3:0] PH_SHEX4  = 4'd11;
	localparam logic [3:0] PH_WAIT   = 4'd12;
	localparam logic [3:0] PH_RAWESC = 4'd13;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hs_q, hs_d;
	logic [15:0] len_q, len_d;
	logic        esc_q, esc_d;

	logic        emit_byte, emit_utf8, do_end, do_err;
	logic [7:0]  db;
	logic [20:0] cp;
	logic [15:0] acc_new;
	logic [4:0]  hexv;
	logic [3:0][7:0] ub;
	logic [2:0]  un;
	logic [2:0]  n_data;
	logic [16:0] len_sum;

	// Returns {invalid, value} for one ASCII hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'h10;
			if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b0, 4'(c - 8'h30)};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				r = {1'b0, 4'(c - 8'h37)};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				r = {1'b0, 4'(c - 8'h57)};
			end
			return r;
		end
	endfunction

	assign hexv    = hex_value(in_byte);
	assign acc_new = {acc_q[11:0], hexv[3:0]};

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		hs_d      = hs_q;
		esc_d     = esc_q;
		emit_byte = 1'b0;
		emit_utf8 = 1'b0;
		do_end    = 1'b0;
		do_err    = 1'b0;
		db        = in_byte;
		cp        = {5'd0, acc_new};
		if (phase_q == PH_WAIT) begin
			if (in_byte == CH_QUOTE) begin
				phase_d = PH_PLAIN;
			end
		end else if (raw_mode) begin
			if (phase_q == PH_RAWESC) begin
				if (in_byte == 8'h00) begin
					do_err = 1'b1;
				end else begin
					phase_d   = PH_PLAIN;
					emit_byte = 1'b1;
				end
			end else if (in_byte == CH_QUOTE) begin
				do_end = 1'b1;
			end else if (in_byte == 8'h00) begin
				do_err = 1'b1;
			end else begin
				emit_byte = 1'b1;
				if (in_byte == CH_BSL) begin
					esc_d   = 1'b1;
					phase_d = PH_RAWESC;
				end
			end
		end else if (in_byte == 8'h00) begin
			do_err = 1'b1;
		end else if (phase_q == PH_ESC) begin
			phase_d   = PH_PLAIN;
			emit_byte = 1'b1;
			case (in_byte)
				CH_B: db = 8'h08;
				CH_F: db = 8'h0C;
				CH_N: db = 8'h0A;
				CH_R: db = 8'h0D;
				CH_T: db = 8'h09;
				CH_U: begin
					emit_byte = 1'b0;
					acc_d     = 16'd0;
					phase_d   = PH_HEX1;
				end
				default: db = in_byte;
			endcase
		end else if ((phase_q >= PH_HEX1 && phase_q <= PH_HEX4) ||
				(phase_q >= PH_SHEX1 && phase_q <= PH_SHEX4)) begin
			if (hexv[4]) begin
				do_err = 1'b1;
			end else begin
				acc_d = acc_new;
				if (phase_q == PH_HEX4) begin
					if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
						// High surrogate: keep its payload and expect a second unit.
						hs_d    = acc_new[9:0];
						phase_d = PH_SBS;
					end else begin
						phase_d   = PH_PLAIN;
						emit_utf8 = 1'b1;
					end
				end else if (phase_q == PH_SHEX4) begin
					if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
						do_err = 1'b1;
					end else begin
						cp        = {1'b0, hs_q, acc_new[9:0]} + 21'h10000;
						phase_d   = PH_PLAIN;
						emit_utf8 = 1'b1;
					end
				end else begin
					phase_d = phase_q + 4'd1;
				end
			end
		end else if (phase_q == PH_SBS) begin
			if (in_byte != CH_BSL) begin
				do_err = 1'b1;
			end else begin
				phase_d = PH_SU;
			end
		end else if (phase_q == PH_SU) begin
			if (in_byte != CH_U) begin
				do_err = 1'b1;
			end else begin
				acc_d   = 16'd0;
				phase_d = PH_SHEX1;
			end
		end else begin
			phase_d = PH_PLAIN;
			if (in_byte == CH_QUOTE) begin
				do_end = 1'b1;
			end else if (in_byte == CH_BSL) begin
				esc_d   = 1'b1;
				phase_d = PH_ESC;
			end else begin
				emit_byte = 1'b1;
			end
		end
	end

	// UTF-8 encoder for one code point of up to 21 bits.
	always_comb begin
		ub = '0;
		if (cp <= 21'h7F) begin
			un    = 3'd1;
			ub[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			un    = 3'd2;
			ub[0] = 8'hC0 | {3'd0, cp[10:6]};
			ub[1] = 8'h80 | {2'd0, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			un    = 3'd3;
			ub[0] = 8'hE0 | {4'd0, cp[15:12]};
			ub[1] = 8'h80 | {2'd0, cp[11:6]};
			ub[2] = 8'h80 | {2'd0, cp[5:0]};
		end else begin
			un    = 3'd4;
			ub[0] = 8'hF0 | {5'd0, cp[20:18]};
			ub[1] = 8'h80 | {2'd0, cp[17:12]};
			ub[2] = 8'h80 | {2'd0, cp[11:6]};
			ub[3] = 8'h80 | {2'd0, cp[5:0]};
		end
	end

	always_comb begin
		burst       = '0;
		n_data      = 3'd0;
		burst.kind  = jsu_pkg::KIND_DATA;
		if (emit_utf8) begin
			n_data      = un;
			burst.bytes = ub;
		end else if (emit_byte) begin
			n_data         = 3'd1;
			burst.bytes[0] = db;
		end
		burst.count = n_data;
		if (do_end) begin
			burst.count = 3'd1;
			burst.kind  = jsu_pkg::KIND_END;
			burst.esc   = esc_q;
			burst.len   = len_q;
		end else if (do_err) begin
			burst.count = 3'd1;
			burst.kind  = jsu_pkg::KIND_ERROR;
		end
	end

	// Length counts data bytes and holds at the cap.
	assign len_sum = {1'b0, len_q} + {14'd0, n_data};
	assign len_d   = (len_sum > {1'b0, LEN_CAP}) ? LEN_CAP : len_sum[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			acc_q   <= 16'd0;
			hs_q    <= 10'd0;
			len_q   <= 16'd0;
			esc_q   <= 1'b0;
		end else if (clear) begin
			phase_q <= PH_PLAIN;
			acc_q   <= 16'd0;
			hs_q    <= 10'd0;
			len_q   <= 16'd0;
			esc_q   <= 1'b0;
		end else if (accept) begin
			if (do_end || do_err || (phase_q == PH_WAIT && phase_d == PH_PLAIN)) begin
				phase_q <= do_err ? PH_WAIT : PH_PLAIN;
				acc_q   <= 16'd0;
				hs_q    <= 10'd0;
				len_q   <= 16'd0;
				esc_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				hs_q    <= hs_d;
				len_q   <= len_d;
				esc_q   <= esc_d;
			end
		end
	end

`ifndef ASSERT_OFF
	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (phase_q == PH_PLAIN && len_q == 16'd0 && !esc_q))
		else $error("decode state not cleared after register write");
	a_len_capped: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_CAP)
		else $error("decoded length passed its cap");
	a_esc_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ESC || phase_q == PH_RAWESC || phase_q == PH_SBS) |-> esc_q)
		else $error("escape phase without escape flag");
`endif

endmodule

`default_nettype wire

>>> src/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register that holds one burst and drains it one item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_outbuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire jsu_pkg::jsu_burst_t burst,
	output logic                     can_take,
	output logic                     valid,
	input  wire logic                ready,
	output logic [7:0]               out_byte,
	output logic [1:0]               kind,
	output logic                     escapes_seen,
	output logic [15:0]              decoded_length,
	output logic                     last
);

	logic [2:0]      cnt_q;
	logic [3:0][7:0] bytes_q;
	logic [1:0]      kind_q;
	logic            esc_q;
	logic [15:0]     len_q;
	logic            pop;

	assign valid    = (cnt_q != 3'd0);
	assign pop      = valid && ready;
	assign can_take = (cnt_q == 3'd0) || (cnt_q == 3'd1 && ready);

	assign out_byte       = bytes_q[0];
	assign kind           = kind_q;
	assign escapes_seen   = esc_q;
	assign decoded_length = len_q;
	assign last           = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load && burst.count != 3'd0) begin
			cnt_q <= burst.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && burst.count != 3'd0) begin
			bytes_q <= burst.bytes;
			kind_q  <= burst.kind;
			esc_q   <= burst.esc;
			len_q   <= burst.len;
		end else if (pop) begin
			bytes_q <= {8'd0, bytes_q[3], bytes_q[2], bytes_q[1]};
		end
	end

endmodule

`default_nettype wire

>>> src/json_string_unescape_utf8.sv
// The first result of an accepted byte reaches the master side in the next cycle.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready
// is high; a byte that expands to N UTF-8 bytes holds s_tready low while the result
// register drains. Reset (arst_n low) clears raw_mode, the decode state and the
// result register at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string body decoder with escape handling and UTF-8 output.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 #(
	// Cap on the decoded length reported with each end item.
	parameter int unsigned MAX_STRING_LEN = jsu_pkg::MAX_STRING_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream: one byte of the string body per transaction.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] out_byte, [8] escapes_seen,
	                                    // [24:9] decoded_length, [31:25] zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic                raw_mode_q;
	logic                cfg_wr;
	logic                accept;
	logic                can_take;
	jsu_pkg::jsu_burst_t burst;
	logic [7:0]          out_byte;
	logic                escapes_seen;
	logic [15:0]         decoded_length;

	// The only register, raw_mode, answers whenever paddr[2] is low. Writing it also
	// abandons any string in progress, so the decoder clears on the same edge.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, raw_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			raw_mode_q <= pwdata[0];
		end
	end

	// A byte is taken whenever the result register is empty or is about to hand
	// over its final item, so single-result bytes stream at full rate.
	assign s_tready = can_take;
	assign accept   = s_tvalid && s_tready;

	// The decoder works out every result of the byte in one pass from its
	// current state; the state advances on the accepting edge.
	jsu_decode #(
		.MAX_STRING_LEN(MAX_STRING_LEN)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (s_tdata),
		.raw_mode (raw_mode_q),
		.clear    (cfg_wr),
		.burst    (burst)
	);

	// The result register takes the whole burst and hands it out one item per
	// transaction, marking the final one with tlast.
	jsu_outbuf u_outbuf (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.burst          (burst),
		.can_take       (can_take),
		.valid          (m_tvalid),
		.ready          (m_tready),
		.out_byte       (out_byte),
		.kind           (m_tuser),
		.escapes_seen   (escapes_seen),
		.decoded_length (decoded_length),
		.last           (m_tlast)
	);

	assign m_tdata = {7'd0, decoded_length, escapes_seen, out_byte};

endmodule

`default_nettype wire
